// ===== rtl/dbms_pkg.sv =====
package dbms_pkg;

    localparam int unsigned CODE_W   = 3;
    localparam int unsigned COUNT_W  = 4;
    localparam int unsigned TYPE_W   = 2;
    localparam int unsigned RANGE_W  = 3;
    localparam int unsigned TICK_W   = 8;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [COUNT_W-1:0] DEBOUNCE_RESET = 4'd3;
    localparam logic [COUNT_W-1:0] DEBOUNCE_MAX   = 4'd14;
    localparam logic [TICK_W-1:0]  REFRESH_RESET  = 8'd20;
    localparam logic [TYPE_W-1:0]  TYPE_LAST      = 2'd2;
    localparam logic [RANGE_W-1:0] RANGE_LAST     = 3'd4;

    typedef enum logic [CODE_W-1:0] {
        BTN_NONE       = 3'd0,
        BTN_TYPE_UP    = 3'd1,
        BTN_TYPE_DOWN  = 3'd2,
        BTN_RANGE_UP   = 3'd3,
        BTN_RANGE_DOWN = 3'd4,
        BTN_AUTO       = 3'd5
    } t_button;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE_TICKS = 1'b0,
        CFG_REFRESH_PERIOD = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic               press_accepted;
        logic [TYPE_W-1:0]  type_select;
        logic [RANGE_W-1:0] range_select;
        logic               auto_range;
        logic               refresh_strobe;
    } t_result;

endpackage

// ===== rtl/dbms_if.sv =====
interface dbms_in_if;
    import dbms_pkg::*;

    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] button_code;

    modport source (output valid, output button_code, input ready);
    modport sink (input valid, input button_code, output ready);
endinterface

interface dbms_out_if;
    import dbms_pkg::*;

    logic               valid;
    logic               ready;
    logic               press_accepted;
    logic [TYPE_W-1:0]  type_select;
    logic [RANGE_W-1:0] range_select;
    logic               auto_range;
    logic               refresh_strobe;

    modport source (
        output valid, output press_accepted, output type_select,
        output range_select, output auto_range, output refresh_strobe,
        input ready
    );
    modport sink (
        input valid, input press_accepted, input type_select,
        input range_select, input auto_range, input refresh_strobe,
        output ready
    );
endinterface

// ===== rtl/dbms_core.sv =====
module dbms_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dbms_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dbms_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           i_take,
    input  logic [dbms_pkg::CODE_W-1:0]    i_button_code,
    output dbms_pkg::t_result              o_result
);
    import dbms_pkg::*;

    logic [COUNT_W-1:0] r_debounce_ticks;
    logic [TICK_W-1:0]  r_refresh_period;
    logic [CODE_W-1:0]  r_last_button, n_last_button;
    logic [COUNT_W-1:0] r_stable_count, n_stable_count;
    logic [TYPE_W-1:0]  r_type_reg, n_type_reg;
    logic [RANGE_W-1:0] r_range_reg, n_range_reg;
    logic               r_auto_reg, n_auto_reg;
    logic [TICK_W-1:0]  r_tick_count, n_tick_count;

    logic [COUNT_W-1:0] thr;
    logic [TICK_W-1:0]  tick_inc;
    logic               act;
    logic               accepted;
    logic               strobe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks <= DEBOUNCE_RESET;
            r_refresh_period <= REFRESH_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_idx))
                CFG_DEBOUNCE_TICKS: r_debounce_ticks <= i_cfg_wdata[COUNT_W-1:0];
                CFG_REFRESH_PERIOD: r_refresh_period <= i_cfg_wdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        thr = (r_debounce_ticks > DEBOUNCE_MAX) ? DEBOUNCE_MAX : r_debounce_ticks;
        n_last_button  = r_last_button;
        n_stable_count = r_stable_count;
        n_type_reg     = r_type_reg;
        n_range_reg    = r_range_reg;
        n_auto_reg     = r_auto_reg;
        act            = 1'b0;
        accepted       = 1'b0;

        if (i_button_code == r_last_button) begin
            if (r_stable_count == thr && i_button_code != BTN_NONE) begin
                act            = 1'b1;
                n_stable_count = r_stable_count + 1'b1;
            end else if (r_stable_count <= thr) begin
                n_stable_count = r_stable_count + 1'b1;
            end
        end else begin
            n_stable_count = '0;
            n_last_button  = i_button_code;
        end

        if (act) begin
            case (t_button'(i_button_code))
                BTN_TYPE_UP: begin
                    n_type_reg = (r_type_reg >= TYPE_LAST) ? '0 : r_type_reg + 1'b1;
                    accepted   = 1'b1;
                end
                BTN_TYPE_DOWN: begin
                    n_type_reg = (r_type_reg == '0 || r_type_reg > TYPE_LAST) ?
                                 TYPE_LAST : r_type_reg - 1'b1;
                    accepted   = 1'b1;
                end
                BTN_RANGE_UP: begin
                    if (!r_auto_reg) begin
                        n_range_reg = (r_range_reg >= RANGE_LAST) ? '0 : r_range_reg + 1'b1;
                    end
                    accepted = 1'b1;
                end
                BTN_RANGE_DOWN: begin
                    if (!r_auto_reg) begin
                        n_range_reg = (r_range_reg == '0 || r_range_reg > RANGE_LAST) ?
                                      RANGE_LAST : r_range_reg - 1'b1;
                    end
                    accepted = 1'b1;
                end
                BTN_AUTO: begin
                    n_auto_reg = ~r_auto_reg;
                    accepted   = 1'b1;
                end
                default: ;
            endcase
        end

        tick_inc     = r_tick_count + 1'b1;
        strobe       = (tick_inc == r_refresh_period);
        n_tick_count = strobe ? '0 : tick_inc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_button  <= '0;
            r_stable_count <= '0;
            r_type_reg     <= '0;
            r_range_reg    <= '0;
            r_auto_reg     <= 1'b0;
            r_tick_count   <= '0;
        end else if (i_take) begin
            r_last_button  <= n_last_button;
            r_stable_count <= n_stable_count;
            r_type_reg     <= n_type_reg;
            r_range_reg    <= n_range_reg;
            r_auto_reg     <= n_auto_reg;
            r_tick_count   <= n_tick_count;
        end
    end

    assign o_result.press_accepted = accepted;
    assign o_result.type_select    = n_type_reg;
    assign o_result.range_select   = n_range_reg;
    assign o_result.auto_range     = n_auto_reg;
    assign o_result.refresh_strobe = strobe;

    a_type_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_type_reg <= TYPE_LAST)
        else $error("type register left its range");

    a_range_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_range_reg <= RANGE_LAST)
        else $error("range register left its range");

    a_press_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && act) |=> (r_stable_count != '0))
        else $error("count did not move past the threshold after a press");

    a_strobe_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && strobe) |=> (r_tick_count == '0))
        else $error("tick counter not cleared after a refresh strobe");

endmodule

// ===== rtl/debounced_button_mode_selector.sv =====
// Channel | Direction | Payload                                          | Transfer
// i_in    | in        | button_code                                      | valid & ready
// o_out   | out       | press_accepted, type_select, range_select,       | valid & ready
//         |           | auto_range, refresh_strobe                       |
// Each tick is handled at its transfer edge: the state is updated there and its
// result is written into a two-entry output buffer at the same edge.
// A new tick is taken every cycle while the buffer has a free entry, so a stalled
// sink blocks the input only after two results wait.
// Reset is synchronous and active low; it clears the state, the buffer and
// restores the register defaults.
module debounced_button_mode_selector (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    dbms_in_if.sink                         i_in,
    dbms_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [dbms_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dbms_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import dbms_pkg::*;

    t_result    result;
    t_result    r_buf [2];
    logic [1:0] r_count;
    logic       r_head;
    logic       push;
    logic       pop;
    logic       tail;
    t_result    head_item;

    assign i_in.ready = (r_count != 2'd2);
    assign push       = i_in.valid && i_in.ready;
    assign pop        = o_out.valid && o_out.ready;
    assign tail       = r_head ^ r_count[0];

    dbms_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_take        (push),
        .i_button_code (i_in.button_code),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[tail] <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_head  <= 1'b0;
        end else begin
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
            if (pop) begin
                r_head <= ~r_head;
            end
        end
    end

    assign head_item = r_buf[r_head];

    assign o_out.valid          = (r_count != 2'd0);
    assign o_out.press_accepted = head_item.press_accepted;
    assign o_out.type_select    = head_item.type_select;
    assign o_out.range_select   = head_item.range_select;
    assign o_out.auto_range     = head_item.auto_range;
    assign o_out.refresh_strobe = head_item.refresh_strobe;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("output buffer overfilled");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_count == $past(r_count) + 2'd1))
        else $error("buffer count did not follow an input transfer");

    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !push) |=> (r_count == $past(r_count) - 2'd1))
        else $error("buffer count did not follow an output transfer");

endmodule

// ===== tb/selector_scoreboard.sv =====
`timescale 1ns / 1ps

module selector_scoreboard (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    dbms_in_if                              i_ticks,
    dbms_out_if                             i_panel,
    input  logic                            i_cfg_we,
    input  logic [dbms_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dbms_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output int                              o_pending,
    output int                              o_fail_count
);
    import dbms_pkg::*;

    logic [COUNT_W-1:0] debounce_q;
    logic [TICK_W-1:0]  refresh_q;
    logic [CODE_W-1:0]  held_code;
    logic [COUNT_W-1:0] stable_ticks;
    logic [TYPE_W-1:0]  type_q;
    logic [RANGE_W-1:0] range_q;
    logic               auto_q;
    logic [TICK_W-1:0]  tick_q;

    t_result panel_q[$];
    int      mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic t_result advance_selector(input logic [CODE_W-1:0] code);
        logic [COUNT_W-1:0] thr;
        t_result            r;
        thr = (debounce_q > DEBOUNCE_MAX) ? DEBOUNCE_MAX : debounce_q;
        r.press_accepted = 1'b0;
        if (code != held_code) begin
            held_code = code;
            stable_ticks = '0;
        end else if (stable_ticks == thr && code != BTN_NONE) begin
            stable_ticks = stable_ticks + 1'b1;
            r.press_accepted = 1'b1;
            case (code)
                BTN_TYPE_UP: begin
                    type_q = (type_q >= TYPE_LAST) ? '0 : type_q + 1'b1;
                end
                BTN_TYPE_DOWN: begin
                    type_q = (type_q == '0 || type_q > TYPE_LAST) ? TYPE_LAST : type_q - 1'b1;
                end
                BTN_RANGE_UP: begin
                    if (!auto_q)
                        range_q = (range_q >= RANGE_LAST) ? '0 : range_q + 1'b1;
                end
                BTN_RANGE_DOWN: begin
                    if (!auto_q)
                        range_q = (range_q == '0 || range_q > RANGE_LAST) ?
                                  RANGE_LAST : range_q - 1'b1;
                end
                BTN_AUTO: begin
                    auto_q = ~auto_q;
                end
                default: begin
                    r.press_accepted = 1'b0;
                end
            endcase
        end else if (stable_ticks <= thr) begin
            stable_ticks = stable_ticks + 1'b1;
        end
        tick_q = tick_q + 1'b1;
        r.refresh_strobe = (tick_q == refresh_q);
        if (r.refresh_strobe)
            tick_q = '0;
        r.type_select = type_q;
        r.range_select = range_q;
        r.auto_range = auto_q;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            debounce_q = DEBOUNCE_RESET;
            refresh_q = REFRESH_RESET;
            held_code = BTN_NONE;
            stable_ticks = '0;
            type_q = '0;
            range_q = '0;
            auto_q = 1'b0;
            tick_q = '0;
            panel_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DEBOUNCE_TICKS: debounce_q = i_cfg_wdata[COUNT_W-1:0];
                    CFG_REFRESH_PERIOD: refresh_q = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_panel.valid && i_panel.ready) begin
                if (panel_q.size() == 0) begin
                    $error("result transfer with no tick waiting for it");
                    mismatches++;
                end else begin
                    want = panel_q.pop_front();
                    check_field("press_accepted", 8'(want.press_accepted),
                                8'(i_panel.press_accepted));
                    check_field("type_select", 8'(want.type_select),
                                8'(i_panel.type_select));
                    check_field("range_select", 8'(want.range_select),
                                8'(i_panel.range_select));
                    check_field("auto_range", 8'(want.auto_range),
                                8'(i_panel.auto_range));
                    check_field("refresh_strobe", 8'(want.refresh_strobe),
                                8'(i_panel.refresh_strobe));
                end
            end
            if (i_ticks.valid && i_ticks.ready)
                panel_q.push_back(advance_selector(i_ticks.button_code));
        end
        o_pending <= panel_q.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import dbms_pkg::*;

    localparam logic [CODE_W-1:0] BTN_SPARE_LO = 3'd6;
    localparam logic [CODE_W-1:0] BTN_SPARE_HI = 3'd7;
    localparam int PHASE_TICKS = 172;
    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 8;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic [COUNT_W-1:0]    debounce_now;
    int                    pending;
    int                    fail_count;
    int                    idle_cycles = 0;
    int                    burst_left;

    dbms_in_if  tick_ch ();
    dbms_out_if panel_ch ();

    always #5 clk = ~clk;

    debounced_button_mode_selector dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (tick_ch),
        .o_out       (panel_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    selector_scoreboard scoreboard (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_ticks      (tick_ch),
        .i_panel      (panel_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    task automatic send_tick(input logic [CODE_W-1:0] code);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                tick_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.button_code <= code;
        @(posedge clk);
        while (!tick_ch.ready) @(posedge clk);
        burst_left--;
    endtask

    task automatic hold_button(input logic [CODE_W-1:0] code, input int ticks);
        repeat (ticks) send_tick(code);
    endtask

    task automatic wait_drained();
        tick_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic set_mode(input logic [COUNT_W-1:0] debounce, input logic [TICK_W-1:0] period);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_idx <= CFG_DEBOUNCE_TICKS;
        cfg_wdata <= CFG_DATA_W'(debounce);
        @(posedge clk);
        cfg_idx <= CFG_REFRESH_PERIOD;
        cfg_wdata <= period;
        @(posedge clk);
        cfg_we <= 1'b0;
        debounce_now = debounce;
    endtask

    // Mostly clean holds around the debounce threshold, with some bounce noise.
    task automatic run_random_phase(input int ticks);
        int                sent;
        int                len;
        int                thr;
        logic [CODE_W-1:0] code;
        thr = int'((debounce_now > DEBOUNCE_MAX) ? DEBOUNCE_MAX : debounce_now);
        sent = 0;
        while (sent < ticks) begin
            case ($urandom_range(0, 9))
                0: begin
                    code = CODE_W'($urandom_range(0, 7));
                    len = $urandom_range(1, 2);
                end
                1: begin
                    code = BTN_NONE;
                    len = $urandom_range(1, 4);
                end
                2: begin
                    code = CODE_W'($urandom_range(BTN_SPARE_LO, BTN_SPARE_HI));
                    len = $urandom_range(thr + 1, thr + 3);
                end
                default: begin
                    code = CODE_W'($urandom_range(BTN_TYPE_UP, BTN_AUTO));
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, thr + 1) :
                                                        $urandom_range(thr + 2, thr + 6);
                end
            endcase
            hold_button(code, len);
            sent += len;
        end
    endtask

    initial begin
        int span;
        int mode;
        panel_ch.ready <= 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(4, 60);
            repeat (span) begin
                @(posedge clk);
                case (mode)
                    0: panel_ch.ready <= 1'b1;
                    1: panel_ch.ready <= ($urandom_range(0, 3) != 0);
                    2: panel_ch.ready <= 1'($urandom_range(0, 1));
                    default: panel_ch.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || cfg_we || (tick_ch.valid && tick_ch.ready) ||
            (panel_ch.valid && panel_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        tick_ch.valid <= 1'b0;
        tick_ch.button_code <= BTN_NONE;
        cfg_we <= 1'b0;
        cfg_idx <= CFG_DEBOUNCE_TICKS;
        cfg_wdata <= '0;
        rst_n <= 1'b0;
        burst_left = 0;
        debounce_now = DEBOUNCE_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        run_random_phase(PHASE_TICKS);

        // With a zero threshold a defined button is pressed on its second tick.
        set_mode(4'd0, 8'd1);
        hold_button(BTN_TYPE_UP, 3);
        hold_button(BTN_TYPE_DOWN, 2);
        hold_button(BTN_RANGE_UP, 2);
        hold_button(BTN_RANGE_DOWN, 2);
        hold_button(BTN_AUTO, 2);
        hold_button(BTN_RANGE_UP, 2);
        hold_button(BTN_RANGE_DOWN, 2);
        hold_button(BTN_AUTO, 2);
        hold_button(BTN_SPARE_LO, 2);
        hold_button(BTN_SPARE_HI, 2);
        hold_button(BTN_NONE, 2);
        run_random_phase(PHASE_TICKS);

        set_mode(4'd15, 8'd0);
        run_random_phase(PHASE_TICKS);
        set_mode(4'd14, 8'd255);
        run_random_phase(PHASE_TICKS);
        // The tick counter may now sit above the new period and then has to wrap.
        set_mode(4'd1, 8'd3);
        run_random_phase(PHASE_TICKS);
        set_mode(4'd2, 8'd2);
        run_random_phase(PHASE_TICKS);
        repeat (3) begin
            set_mode(COUNT_W'($urandom_range(0, 15)), TICK_W'($urandom_range(0, 255)));
            run_random_phase(PHASE_TICKS);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/dbms_pkg.sv
rtl/dbms_if.sv
rtl/dbms_core.sv
rtl/debounced_button_mode_selector.sv
tb/selector_scoreboard.sv
tb/testbench.sv
